### rtl/llr_pkg.sv
package llr_pkg;

   // Loop store geometry
   localparam int LOOP_DEPTH = 65536;
   localparam int ADDR_W     = $clog2(LOOP_DEPTH);
   localparam int LEN_W      = ADDR_W + 1;

   // Fixed-point formats
   localparam int FRAC_BITS  = 16;
   localparam int PHASE_W    = 32;
   localparam int INT_W      = PHASE_W - FRAC_BITS;
   localparam int STEP_W     = 20;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = SAMPLE_W + FRAC_BITS + 2;
   localparam int BIT_CNT_W  = $clog2(INT_W);

   // Transaction fields
   localparam int CMD_W      = 2;
   localparam int ADDR_FLD_W = 16;
   localparam int CH_W       = 2;

   // Register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_LENGTH     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_CHANNELS = CSR_INDEX_W'(2);

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;
   localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(LOOP_DEPTH);
   localparam logic [CH_W-1:0]   CH_MONO    = CH_W'(1);
   localparam logic [CH_W-1:0]   CH_RESET   = CH_W'(2);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 2'd0,
      CMD_FRAME   = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

endpackage

### rtl/llr_if.sv
interface llr_req_if import llr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CMD_W-1:0]             command;
   logic                         sample_channel;
   logic [ADDR_FLD_W-1:0]        sample_address;
   logic signed [SAMPLE_W-1:0]   sample_value;

   modport source (output valid, command, sample_channel, sample_address, sample_value,
                   input ready);
   modport sink   (input valid, command, sample_channel, sample_address, sample_value,
                   output ready);
endinterface

interface llr_rsp_if import llr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [SAMPLE_W-1:0]   left_out;
   logic signed [SAMPLE_W-1:0]   right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

### rtl/llr_ram.sv
module llr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### rtl/llr_blend.sv
module llr_blend import llr_pkg::*; (
   input  logic                       clock,
   input  logic                       adv_mul,
   input  logic                       adv_out,
   input  logic signed [SAMPLE_W-1:0] s0,
   input  logic signed [SAMPLE_W-1:0] s1,
   input  logic [FRAC_BITS-1:0]       frac,
   output logic signed [SAMPLE_W-1:0] y
);

   logic signed [SAMPLE_W:0]   diff;
   logic signed [FRAC_BITS:0]  frac_s;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SAMPLE_W-1:0] base_ff;
   logic signed [PROD_W-1:0]   sum;
   logic signed [SAMPLE_W-1:0] y_ff;

   assign diff    = {s1[SAMPLE_W-1], s1} - {s0[SAMPLE_W-1], s0};
   assign frac_s  = {1'b0, frac};
   assign prod_in = PROD_W'(diff) * PROD_W'(frac_s);

   always_ff @(posedge clock) begin
      if (adv_mul) begin
         prod_ff <= prod_in;
         base_ff <= s0;
      end
   end

   // s0 scaled up, plus weighted difference, plus half an LSB; halves round up
   assign sum = (PROD_W'(base_ff) <<< FRAC_BITS) + prod_ff
              + (PROD_W'(1) <<< (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (adv_out) begin
         y_ff <= sum[FRAC_BITS +: SAMPLE_W];
      end
   end

   assign y = y_ff;

endmodule

### rtl/looping_linear_resampler.sv
// Frame path: an accepted frame reaches rsp valid through the store read,
// multiply, and round and output registers. Throughput: one transaction per
// cycle unless rsp back-pressure stalls it; a loop_length write holds req
// ready low while the sample index is reduced modulo the new length.
// Reset (synchronous): phase and index to zero, registers to their defaults,
// pipeline empty. The loop stores are not cleared.
module looping_linear_resampler import llr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   llr_req_if.sink                req_chan,
   llr_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [STEP_W-1:0] phase_step_ff;
   logic [LEN_W-1:0]  loop_length_ff;
   logic [CH_W-1:0]   source_channels_ff;
   logic              len_write;

   assign len_write = csr_write_enable && (csr_index == CSR_LOOP_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff      <= STEP_RESET;
         loop_length_ff     <= LEN_RESET;
         source_channels_ff <= CH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PHASE_STEP:      phase_step_ff      <= csr_write_data[STEP_W-1:0];
            CSR_LOOP_LENGTH:     loop_length_ff     <= csr_write_data[LEN_W-1:0];
            CSR_SOURCE_CHANNELS: source_channels_ff <= csr_write_data[CH_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective loop length: zero acts as one, anything past the store acts as full
   logic [LEN_W-1:0]   len_eff;
   logic [PHASE_W:0]   lenf;
   logic [PHASE_W:0]   step_wide;
   logic [STEP_W-1:0]  step_eff;

   always_comb begin
      priority if (loop_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (loop_length_ff > LEN_W'(LOOP_DEPTH)) begin
         len_eff = LEN_W'(LOOP_DEPTH);
      end else begin
         len_eff = loop_length_ff;
      end
   end

   assign lenf      = (PHASE_W+1)'(len_eff) << FRAC_BITS;
   assign step_wide = (PHASE_W+1)'(phase_step_ff);
   // Limit the step below one loop so a single subtraction wraps the phase
   assign step_eff  = (step_wide > lenf - 1'b1) ? STEP_W'(lenf - 1'b1) : phase_step_ff;

   // ---------------------------------------------------------------------
   // Handshake and pipeline enables
   // ---------------------------------------------------------------------
   logic    v1_ff, v2_ff, rsp_valid_ff;
   logic    en1, en2, en3;
   logic    busy_ff, busy_in;
   logic    accept, frame_go, store_wr;
   cmd_type cmd;

   assign en3 = !rsp_valid_ff || rsp_chan.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1 && !busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd            = cmd_type'(req_chan.command);
   assign frame_go       = accept && (cmd == CMD_FRAME);
   assign store_wr       = accept && (cmd == CMD_WRITE);

   // ---------------------------------------------------------------------
   // Phase and sample index
   // idx_ff tracks the integer part of the phase modulo the loop length,
   // so each frame only needs one conditional subtraction. After a length
   // change it is rebuilt bit by bit by a restoring remainder.
   // ---------------------------------------------------------------------
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;

   logic [PHASE_W:0]     phase_sum;
   logic [PHASE_W-1:0]   phase_adv;
   logic [FRAC_BITS:0]   frac_sum;
   logic [LEN_W:0]       idx_sum;
   logic [ADDR_W-1:0]    idx_adv;
   logic [LEN_W-1:0]     idx_inc;
   logic [ADDR_W-1:0]    idx_next;
   logic [INT_W-1:0]     phase_int;
   logic [LEN_W-1:0]     rem_shift;
   logic [ADDR_W-1:0]    rem_step;

   assign phase_sum = (PHASE_W+1)'(phase_ff) + (PHASE_W+1)'(step_eff);
   assign phase_adv = (phase_sum >= lenf) ? PHASE_W'(phase_sum - lenf)
                                          : PHASE_W'(phase_sum);

   assign frac_sum = (FRAC_BITS+1)'(phase_ff[FRAC_BITS-1:0])
                   + (FRAC_BITS+1)'(step_eff[FRAC_BITS-1:0]);
   assign idx_sum  = (LEN_W+1)'(idx_ff)
                   + (LEN_W+1)'(step_eff[STEP_W-1:FRAC_BITS])
                   + (LEN_W+1)'(frac_sum[FRAC_BITS]);
   assign idx_adv  = (idx_sum >= (LEN_W+1)'(len_eff)) ? ADDR_W'(idx_sum - (LEN_W+1)'(len_eff))
                                                      : ADDR_W'(idx_sum);

   // Following sample, wrapping to the loop start
   assign idx_inc  = LEN_W'(idx_ff) + 1'b1;
   assign idx_next = (idx_inc == len_eff) ? '0 : ADDR_W'(idx_inc);

   assign phase_int = phase_ff[PHASE_W-1:FRAC_BITS];
   assign rem_shift = {idx_ff, phase_int[bit_cnt_ff]};
   assign rem_step  = (rem_shift >= len_eff) ? ADDR_W'(rem_shift - len_eff)
                                             : ADDR_W'(rem_shift);

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      busy_in    = busy_ff;
      bit_cnt_in = bit_cnt_ff;
      if (busy_ff) begin
         // one remainder bit per cycle, most significant first
         idx_in     = rem_step;
         bit_cnt_in = bit_cnt_ff - 1'b1;
         if (bit_cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         unique case (cmd)
            CMD_FRAME: begin
               phase_in = phase_adv;
               idx_in   = idx_adv;
            end
            CMD_RESTART: begin
               phase_in = '0;
               idx_in   = '0;
            end
            CMD_WRITE: ;
            default: ;
         endcase
      end
      if (len_write) begin
         busy_in    = 1'b1;
         bit_cnt_in = BIT_CNT_W'(INT_W - 1);
         idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         idx_ff     <= '0;
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Loop stores: one write and two reads per cycle, registered read data
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] left_a, left_b, right_a, right_b;

   llr_ram #(.WIDTH(SAMPLE_W), .DEPTH(LOOP_DEPTH)) u_left_store (
      .clock     (clock),
      .wr_en     (store_wr && !req_chan.sample_channel),
      .wr_addr   (ADDR_W'(req_chan.sample_address)),
      .wr_data   (req_chan.sample_value),
      .rd_en     (frame_go),
      .rd_addr_a (idx_ff),
      .rd_addr_b (idx_next),
      .rd_data_a (left_a),
      .rd_data_b (left_b)
   );

   llr_ram #(.WIDTH(SAMPLE_W), .DEPTH(LOOP_DEPTH)) u_right_store (
      .clock     (clock),
      .wr_en     (store_wr && req_chan.sample_channel),
      .wr_addr   (ADDR_W'(req_chan.sample_address)),
      .wr_data   (req_chan.sample_value),
      .rd_en     (frame_go),
      .rd_addr_a (idx_ff),
      .rd_addr_b (idx_next),
      .rd_data_a (right_a),
      .rd_data_b (right_b)
   );

   // ---------------------------------------------------------------------
   // Stage 1 sidecar: fraction and channel mode travel with the read
   // ---------------------------------------------------------------------
   logic [FRAC_BITS-1:0] frac1_ff;
   logic                 mono1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         frac1_ff <= phase_ff[FRAC_BITS-1:0];
         mono1_ff <= (source_channels_ff == CH_MONO);
      end
   end

   // Valid bits for store read, multiply and output stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= frame_go;
         if (en2) v2_ff        <= v1_ff;
         if (en3) rsp_valid_ff <= v2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Blend: a mono source feeds the left store to both channels
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] r_s0, r_s1;

   assign r_s0 = mono1_ff ? left_a : right_a;
   assign r_s1 = mono1_ff ? left_b : right_b;

   llr_blend u_blend_left (
      .clock   (clock),
      .adv_mul (en2),
      .adv_out (en3),
      .s0      (left_a),
      .s1      (left_b),
      .frac    (frac1_ff),
      .y       (rsp_chan.left_out)
   );

   llr_blend u_blend_right (
      .clock   (clock),
      .adv_mul (en2),
      .adv_out (en3),
      .s0      (r_s0),
      .s1      (r_s1),
      .frac    (frac1_ff),
      .y       (rsp_chan.right_out)
   );

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

### rtl/llr_checker.sv
module llr_checker import llr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [CMD_W-1:0]       req_command,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_W-1:0]    left_out,
   input logic [SAMPLE_W-1:0]    right_out,
   input logic                   csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index
);

   logic frame_acc;

   assign frame_acc = req_valid && req_ready && (req_command == CMD_FRAME);

   // Empty pipeline after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_out) && $stable(right_out))
      else $error("stalled response changed");

   // Length change blocks new transactions while the index is rebuilt
   a_len_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && (csr_index == CSR_LOOP_LENGTH) |=> !req_ready)
      else $error("request taken during index rebuild");

   // With no back-pressure an accepted frame comes out through the pipeline
   a_frame_latency: assert property (@(posedge clock) disable iff (reset)
      frame_acc ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("frame response missing");

endmodule

bind looping_linear_resampler llr_checker u_llr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_command      (req_chan.command),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .left_out         (rsp_chan.left_out),
   .right_out        (rsp_chan.right_out),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import llr_pkg::*;

   localparam int unsigned CLOCK_HALF_NS  = 4;
   localparam int unsigned RESET_CYCLES   = 4;
   localparam int unsigned DRAIN_CYCLES   = 8;        // pad past the frame pipeline
   localparam int unsigned RANDOM_ITEMS   = 400;
   localparam int unsigned TIMEOUT_CYCLES = 750_000;
   localparam int unsigned REPORT_LIMIT   = 10;

   // Command code that the block must swallow without a response
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic CHAN_LEFT  = 1'b0;
   localparam logic CHAN_RIGHT = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct {
      logic [CMD_W-1:0]           command;
      logic                       channel;
      logic [ADDR_FLD_W-1:0]      address;
      logic signed [SAMPLE_W-1:0] value;
   } request_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } frame_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   llr_req_if req_if ();
   llr_rsp_if rsp_if ();

   looping_linear_resampler uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if.sink),
      .rsp_chan         (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Resampler state as the block should hold it
   logic signed [SAMPLE_W-1:0] left_samples  [LOOP_DEPTH];
   logic signed [SAMPLE_W-1:0] right_samples [LOOP_DEPTH];
   logic [PHASE_W-1:0]         loop_phase;
   logic [STEP_W-1:0]          step_reg;
   logic [LEN_W-1:0]           length_reg;
   logic [CH_W-1:0]            channels_reg;

   // Stimulus planning: which store entries will have been written, and the
   // phase the block will have when the next queued frame reaches it
   bit                 left_loaded  [LOOP_DEPTH];
   bit                 right_loaded [LOOP_DEPTH];
   logic [PHASE_W-1:0] plan_phase;

   request_type pending_requests[$];
   frame_type   expected_frames[$];
   request_type in_flight;
   int unsigned queued_count;
   int unsigned mismatch_count;
   int unsigned send_gap;
   int unsigned stall_left;
   bit          calm;              // no idling on either side while set

   // ------------------------------------------------------------------
   // Frame arithmetic
   // ------------------------------------------------------------------

   // Clamp the loop length register: zero acts as one, oversize as the depth.
   function automatic logic [LEN_W-1:0] effective_length();
      if (length_reg == '0)
         return LEN_W'(1);
      if (length_reg > LEN_W'(LOOP_DEPTH))
         return LEN_W'(LOOP_DEPTH);
      return length_reg;
   endfunction

   // Pick the two neighboring samples and the blend fraction for a phase.
   // The integer part is reduced modulo the loop length, which covers a
   // phase left beyond a loop that just shrank.
   function automatic void locate_taps(input logic [PHASE_W-1:0] ph,
                                       output logic [ADDR_W-1:0] tap0,
                                       output logic [ADDR_W-1:0] tap1,
                                       output logic [FRAC_BITS-1:0] frac);
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] idx;
      len  = effective_length();
      idx  = LEN_W'((ph >> FRAC_BITS) % len);
      tap0 = idx[ADDR_W-1:0];
      tap1 = (idx + 1 == len) ? '0 : ADDR_W'(idx + 1);
      frac = ph[FRAC_BITS-1:0];
   endfunction

   // Advance by the step, limited to one fraction unit below the loop length,
   // and wrap with a single subtraction.
   function automatic logic [PHASE_W-1:0] phase_after(input logic [PHASE_W-1:0] ph);
      logic [63:0] span;
      logic [63:0] step;
      logic [63:0] sum;
      span = 64'(effective_length()) << FRAC_BITS;
      step = 64'(step_reg);
      if (step > span - 1)
         step = span - 1;
      sum = 64'(ph) + step;
      if (sum >= span)
         sum = sum - span;
      return sum[PHASE_W-1:0];
   endfunction

   // Linear blend, rounded to nearest with halves toward plus infinity
   function automatic logic signed [SAMPLE_W-1:0] interpolate(
         input logic signed [SAMPLE_W-1:0] a,
         input logic signed [SAMPLE_W-1:0] b,
         input logic [FRAC_BITS-1:0]       frac);
      longint acc;
      acc = longint'(a) * (longint'(1) << FRAC_BITS)
          + (longint'(b) - longint'(a)) * longint'(frac);
      acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return acc[SAMPLE_W-1:0];
   endfunction

   // Produce the frame for the current phase and step the phase on.
   function automatic frame_type render_frame();
      logic [ADDR_W-1:0]    tap0;
      logic [ADDR_W-1:0]    tap1;
      logic [FRAC_BITS-1:0] frac;
      frame_type            f;
      locate_taps(loop_phase, tap0, tap1, frac);
      f.left = interpolate(left_samples[tap0], left_samples[tap1], frac);
      // Any channel code other than mono means a stereo source
      if (channels_reg == CH_MONO)
         f.right = f.left;
      else
         f.right = interpolate(right_samples[tap0], right_samples[tap1], frac);
      loop_phase = phase_after(loop_phase);
      return f;
   endfunction

   // Apply one accepted transaction to the predicted state.
   function automatic void consume_request(input request_type r);
      case (r.command)
         CMD_WRITE: begin
            // The address field cannot reach past the store at this depth
            if (r.channel == CHAN_RIGHT)
               right_samples[r.address] = r.value;
            else
               left_samples[r.address] = r.value;
         end
         CMD_FRAME:   expected_frames.insert(expected_frames.size(), render_frame());
         CMD_RESTART: loop_phase = '0;
         default: ;
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 10);
      return $urandom_range(15, 30);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Queue a transaction and track what it does to the plan.
   function automatic void queue_request(input logic [CMD_W-1:0]           command,
                                         input logic                       channel,
                                         input logic [ADDR_FLD_W-1:0]      address,
                                         input logic signed [SAMPLE_W-1:0] value);
      request_type r;
      r.command = command;
      r.channel = channel;
      r.address = address;
      r.value   = value;
      pending_requests.insert(pending_requests.size(), r);
      if (command == CMD_WRITE) begin
         if (channel == CHAN_RIGHT)
            right_loaded[address] = 1'b1;
         else
            left_loaded[address] = 1'b1;
      end
      if (command == CMD_RESTART)
         plan_phase = '0;
      if (command != CMD_UNUSED)
         queued_count++;
   endfunction

   // Queue a frame; first load any tap the block would read unwritten.
   function automatic void queue_frame();
      logic [ADDR_W-1:0]    tap0;
      logic [ADDR_W-1:0]    tap1;
      logic [FRAC_BITS-1:0] frac;
      locate_taps(plan_phase, tap0, tap1, frac);
      if (!left_loaded[tap0])
         queue_request(CMD_WRITE, CHAN_LEFT, tap0, random_sample());
      if (!left_loaded[tap1])
         queue_request(CMD_WRITE, CHAN_LEFT, tap1, random_sample());
      if (channels_reg != CH_MONO) begin
         if (!right_loaded[tap0])
            queue_request(CMD_WRITE, CHAN_RIGHT, tap0, random_sample());
         if (!right_loaded[tap1])
            queue_request(CMD_WRITE, CHAN_RIGHT, tap1, random_sample());
      end
      queue_request(CMD_FRAME, 1'($urandom), ADDR_FLD_W'($urandom), SAMPLE_W'($urandom));
      plan_phase = phase_after(plan_phase);
   endfunction

   function automatic void queue_noise(input logic [CMD_W-1:0] command);
      queue_request(command, 1'($urandom), ADDR_FLD_W'($urandom), SAMPLE_W'($urandom));
   endfunction

   // Write one register while the block is idle; mirror it in the model.
   task automatic configure(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_PHASE_STEP:      step_reg     = data[STEP_W-1:0];
         CSR_LOOP_LENGTH:     length_reg   = data[LEN_W-1:0];
         CSR_SOURCE_CHANNELS: channels_reg = data[CH_W-1:0];
         default: ;
      endcase
   endtask

   // Wait until every queued transaction went in and every frame came out,
   // then let the pipeline drain before the next register write.
   task automatic settle();
      while (pending_requests.size() != 0 || req_if.valid || expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      plan_phase = loop_phase;
   endtask

   // ------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   initial begin
      #(longint'(TIMEOUT_CYCLES) * 2 * CLOCK_HALF_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // Request driver: present queued transactions, idle between them
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         // Predict on the transaction that completes at this edge
         if (req_if.valid && req_if.ready)
            consume_request(in_flight);
         // Hold the current transaction until it is taken
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap     <= send_gap - 1;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               in_flight                = pending_requests.pop_front();
               req_if.valid            <= 1'b1;
               req_if.command          <= in_flight.command;
               req_if.sample_channel   <= in_flight.channel;
               req_if.sample_address   <= in_flight.address;
               req_if.sample_value     <= in_flight.value;
               send_gap                <= calm ? 0 : pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: stall at random, check each frame in order
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_frames.size() == 0) begin
               note_failure($sformatf("unexpected frame left %0d right %0d",
                                      rsp_if.left_out, rsp_if.right_out));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_if.left_out !== want.left || rsp_if.right_out !== want.right)
                  note_failure($sformatf(
                     "frame mismatch: expected left %0d right %0d, got left %0d right %0d",
                     want.left, want.right, rsp_if.left_out, rsp_if.right_out));
            end
         end
         // Drop ready for a random stretch now and then
         if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left   <= pick_gap();
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin
      int unsigned              target;
      int unsigned              count;
      int unsigned              pick;
      logic [CSR_DATA_W-1:0]    data;

      // Drive every input to a known value from time zero
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_if.valid          = 1'b0;
      req_if.command        = '0;
      req_if.sample_channel = 1'b0;
      req_if.sample_address = '0;
      req_if.sample_value   = '0;
      rsp_if.ready          = 1'b0;
      calm                  = 1'b1;
      queued_count          = 0;
      mismatch_count        = 0;

      // Power-on register values and an empty phase
      loop_phase   = '0;
      plan_phase   = '0;
      step_reg     = STEP_RESET;
      length_reg   = LEN_RESET;
      channels_reg = CH_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Two-sample stereo loop at half speed: full-scale steps, the midpoint
      // rounding case, the neighbor wrapping to zero and the phase wrap
      configure(CSR_PHASE_STEP, CSR_DATA_W'(32768));
      configure(CSR_LOOP_LENGTH, CSR_DATA_W'(2));
      configure(CSR_SOURCE_CHANNELS, CSR_DATA_W'(CH_RESET));
      plan_phase = loop_phase;
      queue_request(CMD_WRITE, CHAN_LEFT, ADDR_FLD_W'(0), SAMPLE_MAX);
      queue_request(CMD_WRITE, CHAN_LEFT, ADDR_FLD_W'(1), SAMPLE_MIN);
      queue_request(CMD_WRITE, CHAN_RIGHT, ADDR_FLD_W'(0), SAMPLE_MIN);
      queue_request(CMD_WRITE, CHAN_RIGHT, ADDR_FLD_W'(1), SAMPLE_MAX);
      repeat (4) queue_frame();
      queue_noise(CMD_RESTART);
      queue_frame();
      queue_noise(CMD_UNUSED);
      queue_frame();
      settle();

      // Mono source with the largest step, which must be clamped
      configure(CSR_SOURCE_CHANNELS, CSR_DATA_W'(CH_MONO));
      configure(CSR_PHASE_STEP, CSR_DATA_W'(20'hFFFFF));
      plan_phase = loop_phase;
      repeat (2) queue_frame();
      settle();

      // Zero loop length acts as one; zero channel code is stereo; zero step
      configure(CSR_LOOP_LENGTH, '0);
      configure(CSR_SOURCE_CHANNELS, '0);
      configure(CSR_PHASE_STEP, '0);
      plan_phase = loop_phase;
      repeat (2) queue_frame();
      settle();

      // Oversize length acts as the full store, then shrink under the phase
      configure(CSR_LOOP_LENGTH, CSR_DATA_W'(17'h1FFFF));
      configure(CSR_SOURCE_CHANNELS, CSR_DATA_W'(3));
      configure(CSR_PHASE_STEP, CSR_DATA_W'(20'hFFFFF));
      plan_phase = loop_phase;
      repeat (3) queue_frame();
      settle();
      configure(CSR_LOOP_LENGTH, CSR_DATA_W'(5));
      plan_phase = loop_phase;
      repeat (3) queue_frame();
      settle();

      // Random phases: new settings, then a burst of mostly frames
      target = queued_count + RANDOM_ITEMS;
      while (queued_count < target) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       data = '0;
               1:       data = CSR_DATA_W'(20'hFFFFF);
               2:       data = CSR_DATA_W'($urandom);
               default: data = CSR_DATA_W'($urandom_range(1, 3 * 65536));
            endcase
            configure(CSR_PHASE_STEP, data);
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       data = '0;
               1:       data = CSR_DATA_W'(1);
               2:       data = CSR_DATA_W'(LOOP_DEPTH);
               3:       data = CSR_DATA_W'($urandom_range(LOOP_DEPTH + 1, 131071));
               4:       data = CSR_DATA_W'(2);
               default: data = CSR_DATA_W'($urandom_range(2, 48));
            endcase
            configure(CSR_LOOP_LENGTH, data);
         end
         if ($urandom_range(0, 2) == 0)
            configure(CSR_SOURCE_CHANNELS, CSR_DATA_W'($urandom_range(0, 3)));
         plan_phase = loop_phase;

         count = $urandom_range(10, 40);
         repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
               queue_frame();
            else if (pick < 82)
               queue_request(CMD_WRITE, 1'($urandom),
                             ADDR_FLD_W'($urandom_range(0, effective_length() - 1)),
                             random_sample());
            else if (pick < 88)
               queue_request(CMD_WRITE, 1'($urandom), ADDR_FLD_W'($urandom),
                             random_sample());
            else if (pick < 95)
               queue_noise(CMD_RESTART);
            else
               queue_noise(CMD_UNUSED);
         end
         settle();
      end

      if (expected_frames.size() != 0)
         note_failure($sformatf("%0d expected frames never arrived", expected_frames.size()));

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
